@@ design/ranging_burst_statistics_defines.svh @@
// Assertion macros used by the ranging burst statistics sequencer (rbs_ctrl).
`ifndef RANGING_BURST_STATISTICS_DEFINES_SVH
`define RANGING_BURST_STATISTICS_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RBS_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RBS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/rbs_pkg.sv @@
// Shared types, constants and the RSSI distance table for the burst statistics block.
package rbs_pkg;

   localparam int TOF_W             = 24;
   localparam int IDX_W             = 7;
   localparam int MEAN_W            = 24;
   localparam int STD_W             = 24;
   localparam int DIST_W            = 19;
   localparam int RDIST_W           = 19;
   localparam int ERR_W             = 7;
   localparam int ROM_W             = 19;
   localparam int MAX_BURST_DEFAULT = 32;

   localparam logic [IDX_W-1:0] ROM_LAST = 7'd108;

   // RSSI index to distance in centimeters.
   localparam logic [ROM_W-1:0] RSSI_CM_ROM [0:108] = '{
      19'd502377, 19'd447744, 19'd399052, 19'd355656, 19'd316979, 19'd282508,
      19'd251785, 19'd224404, 19'd200000, 19'd178250, 19'd158866, 19'd141589,
      19'd126191, 19'd112468, 19'd100237, 19'd89337,  19'd79621,  19'd70963,
      19'd63246,  19'd56368,  19'd50238,  19'd44774,  19'd39905,  19'd35566,
      19'd31698,  19'd28251,  19'd25179,  19'd22440,  19'd20000,  19'd17825,
      19'd15887,  19'd14159,  19'd12619,  19'd11247,  19'd10024,  19'd8934,
      19'd7962,   19'd7096,   19'd6325,   19'd5637,   19'd5024,   19'd4477,
      19'd3991,   19'd3557,   19'd3170,   19'd2825,   19'd2518,   19'd2244,
      19'd2000,   19'd1783,   19'd1589,   19'd1416,   19'd1262,   19'd1125,
      19'd1002,   19'd893,    19'd796,    19'd710,    19'd632,    19'd564,
      19'd502,    19'd448,    19'd399,    19'd356,    19'd317,    19'd283,
      19'd252,    19'd224,    19'd200,    19'd178,    19'd159,    19'd142,
      19'd126,    19'd112,    19'd100,    19'd89,     19'd80,     19'd71,
      19'd63,     19'd56,     19'd50,     19'd45,     19'd40,     19'd36,
      19'd32,     19'd28,     19'd25,     19'd22,     19'd20,     19'd18,
      19'd16,     19'd14,     19'd13,     19'd11,     19'd10,     19'd9,
      19'd8,      19'd7,      19'd6,      19'd6,      19'd5,      19'd4,
      19'd4,      19'd4,      19'd3,      19'd3,      19'd3,      19'd2,
      19'd2
   };

   typedef enum logic [3:0] {
      S_IDLE,
      S_ACCUM,
      S_VMUL,
      S_VSUB,
      S_SQRT,
      S_DSTD,
      S_DMEAN,
      S_MUL3,
      S_DDIST,
      S_DRSSI,
      S_DONE
   } state_type;

   typedef struct packed {
      state_type phase;
      logic      load;
      logic      clear;
   } ctrl_type;

   typedef struct packed {
      logic close;
      logic none_ok;
   } accum_status_type;

   function automatic logic [ROM_W-1:0] rom_lookup(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] sat;
      sat = (idx > ROM_LAST) ? ROM_LAST : idx;
      return RSSI_CM_ROM[sat];
   endfunction

endpackage

@@ design/rbs_alu.sv @@
// Shared adder and subtractor used by every step of the statistics sequence.
module rbs_alu #(
   parameter int W = 58
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  logic         sub,
   output logic [W-1:0] result,
   output logic         carry
);

   logic [W-1:0] b_eff;

   assign b_eff = sub ? ~b : b;

   // With subtraction the carry out is set exactly when a is not below b.
   assign {carry, result} = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, sub};

endmodule

@@ design/rbs_accum.sv @@
// Input capture and burst accumulators: counts, ToF sum, square sum and RSSI distance sum.
module rbs_accum #(
   parameter int MAX_BURST = 32,
   parameter int CNT_W     = 6,
   parameter int SUM_W     = 30,
   parameter int SQ_W      = 52,
   parameter int RSSI_W    = 26
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic signed [rbs_pkg::TOF_W-1:0]  req_tof_ps,
   input  logic [rbs_pkg::IDX_W-1:0]         req_local_rssi,
   input  logic [rbs_pkg::IDX_W-1:0]         req_remote_rssi,
   input  logic                              req_reading_ok,
   input  logic                              req_last_reading,
   input  rbs_pkg::ctrl_type                 ctrl,
   output rbs_pkg::accum_status_type         status,
   output logic [CNT_W-1:0]                  ok_count,
   output logic [CNT_W-1:0]                  fail_count,
   output logic signed [SUM_W-1:0]           tof_sum,
   output logic [SQ_W-1:0]                   tof_square_sum,
   output logic [RSSI_W-1:0]                 rssi_sum
);
   import rbs_pkg::*;

   logic signed [TOF_W-1:0]   tof_ff;
   logic [IDX_W-1:0]          local_ff;
   logic [IDX_W-1:0]          remote_ff;
   logic                      ok_ff;
   logic                      last_ff;

   logic [CNT_W-1:0]          ok_count_ff,  ok_count_in;
   logic [CNT_W-1:0]          fail_count_ff, fail_count_in;
   logic signed [SUM_W-1:0]   tof_sum_ff,   tof_sum_in;
   logic [SQ_W-1:0]           square_sum_ff, square_sum_in;
   logic [RSSI_W-1:0]         rssi_sum_ff,  rssi_sum_in;

   logic signed [2*TOF_W-1:0] square;
   logic [ROM_W:0]            rom_pair;
   logic [CNT_W:0]            total;

   always_ff @(posedge clock) begin
      if (accept) begin
         tof_ff    <= req_tof_ps;
         local_ff  <= req_local_rssi;
         remote_ff <= req_remote_rssi;
         ok_ff     <= req_reading_ok;
         last_ff   <= req_last_reading;
      end
   end

   assign square   = tof_ff * tof_ff;
   assign rom_pair = {1'b0, rom_lookup(local_ff)} + {1'b0, rom_lookup(remote_ff)};

   always_comb begin
      ok_count_in   = ok_count_ff;
      fail_count_in = fail_count_ff;
      tof_sum_in    = tof_sum_ff;
      square_sum_in = square_sum_ff;
      rssi_sum_in   = rssi_sum_ff;
      if (ok_ff) begin
         ok_count_in   = ok_count_ff + CNT_W'(1);
         tof_sum_in    = tof_sum_ff + SUM_W'(tof_ff);
         square_sum_in = square_sum_ff + SQ_W'($unsigned(square));
         rssi_sum_in   = rssi_sum_ff + RSSI_W'(rom_pair);
      end else begin
         fail_count_in = fail_count_ff + CNT_W'(1);
      end
   end

   // A burst also closes when its reading count reaches the burst limit.
   assign total          = {1'b0, ok_count_in} + {1'b0, fail_count_in};
   assign status.close   = last_ff || (total >= (CNT_W + 1)'(MAX_BURST));
   assign status.none_ok = (ok_count_in == '0);

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         ok_count_ff   <= '0;
         fail_count_ff <= '0;
         tof_sum_ff    <= '0;
         square_sum_ff <= '0;
         rssi_sum_ff   <= '0;
      end else if (ctrl.phase == S_ACCUM) begin
         ok_count_ff   <= ok_count_in;
         fail_count_ff <= fail_count_in;
         tof_sum_ff    <= tof_sum_in;
         square_sum_ff <= square_sum_in;
         rssi_sum_ff   <= rssi_sum_in;
      end
   end

   assign ok_count       = ok_count_ff;
   assign fail_count     = fail_count_ff;
   assign tof_sum        = tof_sum_ff;
   assign tof_square_sum = square_sum_ff;
   assign rssi_sum       = rssi_sum_ff;

endmodule

@@ design/rbs_datapath.sv @@
// Statistics datapath: multiply, square root and divide steps on one shared adder.
module rbs_datapath #(
   parameter int CNT_W  = 6,
   parameter int SUM_W  = 30,
   parameter int SQ_W   = 52,
   parameter int RSSI_W = 26,
   parameter int MAG_W  = 29,
   parameter int VW     = 58,
   parameter int RW     = 29
) (
   input  logic                                clock,
   input  rbs_pkg::ctrl_type                   ctrl,
   input  logic [CNT_W-1:0]                    ok_count,
   input  logic [CNT_W-1:0]                    fail_count,
   input  logic signed [SUM_W-1:0]             tof_sum,
   input  logic [SQ_W-1:0]                     tof_square_sum,
   input  logic [RSSI_W-1:0]                   rssi_sum,
   output logic signed [rbs_pkg::MEAN_W-1:0]   rsp_tof_mean_ps,
   output logic [rbs_pkg::STD_W-1:0]           rsp_tof_std_dev_ps,
   output logic signed [rbs_pkg::DIST_W-1:0]   rsp_tof_distance_cm,
   output logic [rbs_pkg::RDIST_W-1:0]         rsp_rssi_distance_cm,
   output logic [rbs_pkg::ERR_W-1:0]           rsp_error_count
);
   import rbs_pkg::*;

   localparam int D100_W = CNT_W + 7;

   logic [VW-1:0]           acc_ff;
   logic [VW-1:0]           opnd_ff;
   logic [VW-1:0]           bits_ff;
   logic [RW-1:0]           root_ff;
   logic [MEAN_W-1:0]       mean_ff;
   logic [STD_W-1:0]        stdv_ff;
   logic [DIST_W-1:0]       dist_ff;

   logic [MEAN_W-1:0]       mean_out_ff;
   logic [STD_W-1:0]        stdv_out_ff;
   logic [DIST_W-1:0]       dist_out_ff;
   logic [RDIST_W-1:0]      rdist_out_ff;
   logic [ERR_W-1:0]        err_out_ff;

   logic                    neg;
   logic signed [SUM_W-1:0] sum_abs;
   logic [MAG_W-1:0]        mag;
   logic [D100_W-1:0]       d100;
   logic [MEAN_W-1:0]       mean_q;
   logic [DIST_W-1:0]       dist_q;
   logic                    none_ok;

   logic [VW-1:0]           alu_a;
   logic [VW-1:0]           alu_b;
   logic                    alu_sub;
   logic [VW-1:0]           alu_res;
   logic                    alu_carry;

   assign neg     = tof_sum[SUM_W-1];
   assign sum_abs = neg ? -tof_sum : tof_sum;
   assign mag     = MAG_W'($unsigned(sum_abs));
   assign d100    = D100_W'(ok_count) * D100_W'(100);
   assign mean_q  = bits_ff[MEAN_W-1:0];
   assign dist_q  = bits_ff[DIST_W-1:0];
   assign none_ok = (ok_count == '0);

   always_comb begin
      case (ctrl.phase)
         S_VMUL, S_MUL3: begin
            alu_a   = acc_ff;
            alu_b   = bits_ff[0] ? opnd_ff : '0;
            alu_sub = 1'b0;
         end
         S_VSUB: begin
            alu_a   = acc_ff;
            alu_b   = bits_ff[0] ? opnd_ff : '0;
            alu_sub = 1'b1;
         end
         S_SQRT: begin
            // Bring down the next two radicand bits and try 4*root + 1.
            alu_a   = {acc_ff[VW-3:0], bits_ff[VW-1:VW-2]};
            alu_b   = VW'({root_ff, 2'b01});
            alu_sub = 1'b1;
         end
         default: begin
            // Restoring division: bring down one dividend bit, try the divisor.
            alu_a   = {acc_ff[VW-2:0], bits_ff[VW-1]};
            alu_b   = opnd_ff;
            alu_sub = 1'b1;
         end
      endcase
   end

   rbs_alu #(
      .W (VW)
   ) u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .sub    (alu_sub),
      .result (alu_res),
      .carry  (alu_carry)
   );

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         case (ctrl.phase)
            S_VMUL: begin
               acc_ff  <= '0;
               opnd_ff <= VW'(tof_square_sum);
               bits_ff <= VW'(ok_count);
            end
            S_VSUB: begin
               opnd_ff <= VW'(mag);
               bits_ff <= VW'(mag);
            end
            S_SQRT: begin
               bits_ff <= acc_ff;
               acc_ff  <= '0;
               root_ff <= '0;
            end
            S_DSTD: begin
               bits_ff <= VW'(root_ff) << (VW - RW);
               acc_ff  <= '0;
               opnd_ff <= VW'(ok_count);
            end
            S_DMEAN: begin
               stdv_ff <= bits_ff[STD_W-1:0];
               bits_ff <= VW'(mag) << (VW - MAG_W);
               acc_ff  <= '0;
               opnd_ff <= VW'(ok_count);
            end
            S_MUL3: begin
               mean_ff <= neg ? -mean_q : mean_q;
               acc_ff  <= '0;
               opnd_ff <= VW'(mag);
               bits_ff <= VW'(2'd3);
            end
            S_DDIST: begin
               bits_ff <= acc_ff << (VW - MAG_W - 2);
               acc_ff  <= '0;
               opnd_ff <= VW'(d100);
            end
            S_DRSSI: begin
               dist_ff <= neg ? -dist_q : dist_q;
               bits_ff <= VW'(rssi_sum) << (VW - RSSI_W);
               acc_ff  <= '0;
               opnd_ff <= VW'(ok_count);
            end
            default: begin
            end
         endcase
      end else begin
         case (ctrl.phase)
            S_VMUL, S_VSUB, S_MUL3: begin
               acc_ff  <= alu_res;
               opnd_ff <= opnd_ff << 1;
               bits_ff <= bits_ff >> 1;
            end
            S_SQRT: begin
               acc_ff  <= alu_carry ? alu_res : alu_a;
               root_ff <= {root_ff[RW-2:0], alu_carry};
               bits_ff <= bits_ff << 2;
            end
            S_DSTD, S_DMEAN, S_DDIST, S_DRSSI: begin
               acc_ff  <= alu_carry ? alu_res : alu_a;
               bits_ff <= {bits_ff[VW-2:0], alu_carry};
            end
            default: begin
            end
         endcase
      end
   end

   // Halving the quotient by the count gives the floor over both RSSI values.
   always_ff @(posedge clock) begin
      if (ctrl.phase == S_DONE) begin
         mean_out_ff  <= none_ok ? '0 : mean_ff;
         stdv_out_ff  <= none_ok ? '0 : stdv_ff;
         dist_out_ff  <= none_ok ? '0 : dist_ff;
         rdist_out_ff <= none_ok ? '0 : bits_ff[RDIST_W:1];
         err_out_ff   <= ERR_W'(fail_count);
      end
   end

   assign rsp_tof_mean_ps      = $signed(mean_out_ff);
   assign rsp_tof_std_dev_ps   = stdv_out_ff;
   assign rsp_tof_distance_cm  = $signed(dist_out_ff);
   assign rsp_rssi_distance_cm = rdist_out_ff;
   assign rsp_error_count      = err_out_ff;

endmodule

@@ design/rbs_ctrl.sv @@
// Sequencer that steps the shared datapath through the per-burst statistics.
`include "ranging_burst_statistics_defines.svh"

module rbs_ctrl #(
   parameter int CNT_W  = 6,
   parameter int MAG_W  = 29,
   parameter int RW     = 29,
   parameter int RSSI_W = 26,
   parameter int STEP_W = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  rbs_pkg::accum_status_type status,
   output logic                      busy,
   output rbs_pkg::ctrl_type         ctrl,
   output logic                      rsp_strobe
);
   import rbs_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] count_ff, count_in;
   logic              strobe_ff, strobe_in;
   logic [STEP_W-1:0] limit;
   logic              computing;

   assign computing = state_ff inside {S_VMUL, S_VSUB, S_SQRT, S_DSTD,
                                       S_DMEAN, S_MUL3, S_DDIST, S_DRSSI};

   // Number of shared-unit steps in each phase, after its load cycle.
   always_comb begin
      case (state_ff)
         S_VMUL:          limit = STEP_W'(CNT_W);
         S_VSUB, S_DMEAN: limit = STEP_W'(MAG_W);
         S_SQRT, S_DSTD:  limit = STEP_W'(RW);
         S_MUL3:          limit = STEP_W'(2);
         S_DDIST:         limit = STEP_W'(MAG_W + 2);
         S_DRSSI:         limit = STEP_W'(RSSI_W);
         default:         limit = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = '0;
      strobe_in  = 1'b0;
      busy       = (state_ff != S_IDLE);
      ctrl.phase = state_ff;
      ctrl.load  = computing && (count_ff == '0);
      ctrl.clear = (state_ff == S_DONE);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_ACCUM;
            end
         end
         S_ACCUM: begin
            if (status.close) begin
               state_in = status.none_ok ? S_DONE : S_VMUL;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DONE: begin
            state_in  = S_IDLE;
            strobe_in = 1'b1;
         end
         default: begin
            if (count_ff == limit) begin
               case (state_ff)
                  S_VMUL:  state_in = S_VSUB;
                  S_VSUB:  state_in = S_SQRT;
                  S_SQRT:  state_in = S_DSTD;
                  S_DSTD:  state_in = S_DMEAN;
                  S_DMEAN: state_in = S_MUL3;
                  S_MUL3:  state_in = S_DDIST;
                  S_DDIST: state_in = S_DRSSI;
                  default: state_in = S_DONE;
               endcase
            end else begin
               count_in = count_ff + STEP_W'(1);
            end
         end
      endcase
   end

   assign rsp_strobe = strobe_ff;

   `RBS_ASSERT_NEXT(a_accept_enters_accum, clock, reset, start && !busy, state_ff == S_ACCUM, "accepted item did not start accumulation")
   `RBS_ASSERT_NOW(a_strobe_follows_done, clock, reset, strobe_ff, $past(state_ff) == S_DONE, "result strobe without a finished burst")
   `RBS_ASSERT_NEXT(a_strobe_single, clock, reset, strobe_ff, !strobe_ff, "result strobe repeated")
   `RBS_ASSERT_NOW(a_count_in_range, clock, reset, 1'b1, count_ff <= limit, "step count ran past its phase")

endmodule

@@ design/ranging_burst_statistics.sv @@
// Top level of the ranging burst statistics block.
//
//  channel   ports                                      handshake
//  -------   -----------------------------------------  ------------------------------
//  request   req_tof_ps, req_local_rssi, req_remote_rssi, taken when start && !busy
//            req_reading_ok, req_last_reading
//  response  rsp_tof_mean_ps, rsp_tof_std_dev_ps,       one-cycle rsp_strobe, no stall
//            rsp_tof_distance_cm, rsp_rssi_distance_cm,
//            rsp_error_count
//
// A reading that does not close its burst is taken in the idle state and added in the
// accumulation state, which has its own 24x24 squarer.
// A closing reading with successes runs eight phases on one shared adder, each a load
// followed by its shift-and-add or shift-and-subtract steps, then the done state raises
// rsp_strobe. A closing reading with no success goes from the accumulation state
// straight to the done state, which raises rsp_strobe.
// Reset is synchronous and clears the sequencer and accumulators; the result has no stall.
module ranging_burst_statistics #(
   parameter int MAX_BURST = rbs_pkg::MAX_BURST_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [rbs_pkg::TOF_W-1:0]    req_tof_ps,
   input  logic [rbs_pkg::IDX_W-1:0]           req_local_rssi,
   input  logic [rbs_pkg::IDX_W-1:0]           req_remote_rssi,
   input  logic                                req_reading_ok,
   input  logic                                req_last_reading,
   output logic                                rsp_strobe,
   output logic signed [rbs_pkg::MEAN_W-1:0]   rsp_tof_mean_ps,
   output logic [rbs_pkg::STD_W-1:0]           rsp_tof_std_dev_ps,
   output logic signed [rbs_pkg::DIST_W-1:0]   rsp_tof_distance_cm,
   output logic [rbs_pkg::RDIST_W-1:0]         rsp_rssi_distance_cm,
   output logic [rbs_pkg::ERR_W-1:0]           rsp_error_count
);
   import rbs_pkg::*;

   localparam int CNT_W  = $clog2(MAX_BURST + 1);
   localparam int SUM_W  = TOF_W + CNT_W;
   localparam int MAG_W  = SUM_W - 1;
   localparam int SQ_W   = 2 * (TOF_W - 1) + CNT_W;
   localparam int RSSI_W = ROM_W + 1 + CNT_W;
   localparam int VW     = ((SQ_W + CNT_W + 1) / 2) * 2;
   localparam int RW     = VW / 2;
   localparam int STEP_W = $clog2(VW + 1);

   ctrl_type                ctrl;
   accum_status_type        status;
   logic                    accept;
   logic [CNT_W-1:0]        ok_count;
   logic [CNT_W-1:0]        fail_count;
   logic signed [SUM_W-1:0] tof_sum;
   logic [SQ_W-1:0]         tof_square_sum;
   logic [RSSI_W-1:0]       rssi_sum;

   assign accept = start && !busy;

   rbs_accum #(
      .MAX_BURST (MAX_BURST),
      .CNT_W     (CNT_W),
      .SUM_W     (SUM_W),
      .SQ_W      (SQ_W),
      .RSSI_W    (RSSI_W)
   ) u_accum (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_tof_ps       (req_tof_ps),
      .req_local_rssi   (req_local_rssi),
      .req_remote_rssi  (req_remote_rssi),
      .req_reading_ok   (req_reading_ok),
      .req_last_reading (req_last_reading),
      .ctrl             (ctrl),
      .status           (status),
      .ok_count         (ok_count),
      .fail_count       (fail_count),
      .tof_sum          (tof_sum),
      .tof_square_sum   (tof_square_sum),
      .rssi_sum         (rssi_sum)
   );

   rbs_datapath #(
      .CNT_W  (CNT_W),
      .SUM_W  (SUM_W),
      .SQ_W   (SQ_W),
      .RSSI_W (RSSI_W),
      .MAG_W  (MAG_W),
      .VW     (VW),
      .RW     (RW)
   ) u_datapath (
      .clock                (clock),
      .ctrl                 (ctrl),
      .ok_count             (ok_count),
      .fail_count           (fail_count),
      .tof_sum              (tof_sum),
      .tof_square_sum       (tof_square_sum),
      .rssi_sum             (rssi_sum),
      .rsp_tof_mean_ps      (rsp_tof_mean_ps),
      .rsp_tof_std_dev_ps   (rsp_tof_std_dev_ps),
      .rsp_tof_distance_cm  (rsp_tof_distance_cm),
      .rsp_rssi_distance_cm (rsp_rssi_distance_cm),
      .rsp_error_count      (rsp_error_count)
   );

   rbs_ctrl #(
      .CNT_W  (CNT_W),
      .MAG_W  (MAG_W),
      .RW     (RW),
      .RSSI_W (RSSI_W),
      .STEP_W (STEP_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .busy       (busy),
      .ctrl       (ctrl),
      .rsp_strobe (rsp_strobe)
   );

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the ranging burst statistics block.
`timescale 1ns / 1ps

module tb;

   import rbs_pkg::*;

   localparam int BURST_CAP    = MAX_BURST_DEFAULT;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 400;
   localparam int RANDOM_ITEMS = 600;
   localparam int PRINT_CAP    = 40;

   localparam logic signed [TOF_W-1:0] TOF_MAX = {1'b0, {(TOF_W-1){1'b1}}};
   localparam logic signed [TOF_W-1:0] TOF_MIN = {1'b1, {(TOF_W-1){1'b0}}};

   typedef struct {
      logic signed [TOF_W-1:0] tof;
      logic [IDX_W-1:0]        local_idx;
      logic [IDX_W-1:0]        remote_idx;
      logic                    ok;
      logic                    last;
   } reading_type;

   typedef struct {
      logic signed [MEAN_W-1:0] mean;
      logic [STD_W-1:0]         std_dev;
      logic signed [DIST_W-1:0] tof_cm;
      logic [RDIST_W-1:0]       rssi_cm;
      logic [ERR_W-1:0]         errors;
   } burst_stats_type;

   // Keeps its own copy of the burst accumulators and the statistics still owed.
   class burst_scoreboard;
      int unsigned        good_n;
      int unsigned        bad_n;
      longint             tof_acc;
      longint unsigned    square_acc;
      int unsigned        cm_acc;
      burst_stats_type    owed_q[$];
      int                 errors;
      int                 readings_seen;
      int                 results_checked;
      int                 cap_closed;
      int                 empty_bursts;

      function new();
         clear_burst();
         errors = 0;
         readings_seen = 0;
         results_checked = 0;
         cap_closed = 0;
         empty_bursts = 0;
      endfunction

      function void clear_burst();
         good_n = 0;
         bad_n = 0;
         tof_acc = 0;
         square_acc = 0;
         cm_acc = 0;
      endfunction

      function int unsigned distance_of(logic [IDX_W-1:0] idx);
         int unsigned k;
         k = (idx > ROM_LAST) ? int'(ROM_LAST) : int'(idx);
         return int'(RSSI_CM_ROM[k]);
      endfunction

      // Bit-by-bit floor square root, most significant bit first.
      function longint unsigned root_floor(longint unsigned v);
         longint unsigned r;
         longint unsigned c;
         r = 0;
         for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= v) r = c;
         end
         return r;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      function void note_reading(reading_type r);
         burst_stats_type want;
         longint          n;
         longint          s;
         longint          q;
         longint unsigned mag;
         longint unsigned spread;
         readings_seen++;
         if (r.ok) begin
            good_n++;
            tof_acc += longint'(r.tof);
            square_acc += longint'(r.tof) * longint'(r.tof);
            cm_acc += distance_of(r.local_idx) + distance_of(r.remote_idx);
         end else begin
            bad_n++;
         end
         if (!r.last && good_n + bad_n < BURST_CAP) return;
         if (!r.last) cap_closed++;
         want.mean = '0;
         want.std_dev = '0;
         want.tof_cm = '0;
         want.rssi_cm = '0;
         want.errors = bad_n[ERR_W-1:0];
         if (good_n != 0) begin
            n = longint'(good_n);
            s = tof_acc;
            mag = (s < 0) ? longint'(-s) : longint'(s);
            spread = longint'(n) * square_acc - mag * mag;
            q = s / n;
            want.mean = q[MEAN_W-1:0];
            q = longint'(root_floor(spread) / longint'(n));
            want.std_dev = q[STD_W-1:0];
            q = (3 * s) / (100 * n);
            want.tof_cm = q[DIST_W-1:0];
            q = longint'(cm_acc) / (2 * n);
            want.rssi_cm = q[RDIST_W-1:0];
         end else begin
            empty_bursts++;
         end
         owed_q.push_back(want);
         clear_burst();
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= PRINT_CAP) $display("tb: MISMATCH %s", msg);
      endtask

      task check_result(burst_stats_type got);
         burst_stats_type want;
         if (owed_q.size() == 0) begin
            report_mismatch("result strobe with no burst closed");
            return;
         end
         want = owed_q.pop_front();
         results_checked++;
         if (got.mean !== want.mean)
            report_mismatch($sformatf("result %0d mean: got %0d, expected %0d",
               results_checked, got.mean, want.mean));
         if (got.std_dev !== want.std_dev)
            report_mismatch($sformatf("result %0d std dev: got %0d, expected %0d",
               results_checked, got.std_dev, want.std_dev));
         if (got.tof_cm !== want.tof_cm)
            report_mismatch($sformatf("result %0d tof distance: got %0d, expected %0d",
               results_checked, got.tof_cm, want.tof_cm));
         if (got.rssi_cm !== want.rssi_cm)
            report_mismatch($sformatf("result %0d rssi distance: got %0d, expected %0d",
               results_checked, got.rssi_cm, want.rssi_cm));
         if (got.errors !== want.errors)
            report_mismatch($sformatf("result %0d error count: got %0d, expected %0d",
               results_checked, got.errors, want.errors));
      endtask
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic signed [TOF_W-1:0]    req_tof_ps = '0;
   logic [IDX_W-1:0]           req_local_rssi = '0;
   logic [IDX_W-1:0]           req_remote_rssi = '0;
   logic                       req_reading_ok = 1'b0;
   logic                       req_last_reading = 1'b0;
   logic                       rsp_strobe;
   logic signed [MEAN_W-1:0]   rsp_tof_mean_ps;
   logic [STD_W-1:0]           rsp_tof_std_dev_ps;
   logic signed [DIST_W-1:0]   rsp_tof_distance_cm;
   logic [RDIST_W-1:0]         rsp_rssi_distance_cm;
   logic [ERR_W-1:0]           rsp_error_count;

   burst_scoreboard sb = new();
   int              idle_cycles = 0;
   int              n_sent = 0;
   int              pace_left = 0;
   bit              steady = 1'b0;
   bit              held_low = 1'b1;

   ranging_burst_statistics #(
      .MAX_BURST(BURST_CAP)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_tof_ps(req_tof_ps),
      .req_local_rssi(req_local_rssi),
      .req_remote_rssi(req_remote_rssi),
      .req_reading_ok(req_reading_ok),
      .req_last_reading(req_last_reading),
      .rsp_strobe(rsp_strobe),
      .rsp_tof_mean_ps(rsp_tof_mean_ps),
      .rsp_tof_std_dev_ps(rsp_tof_std_dev_ps),
      .rsp_tof_distance_cm(rsp_tof_distance_cm),
      .rsp_rssi_distance_cm(rsp_rssi_distance_cm),
      .rsp_error_count(rsp_error_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Samples both channels on the edge, before any of this edge's updates land.
   always @(posedge clock) begin : monitor
      reading_type     rd;
      burst_stats_type got;
      if (!reset) begin
         if (rsp_strobe) begin
            got.mean = rsp_tof_mean_ps;
            got.std_dev = rsp_tof_std_dev_ps;
            got.tof_cm = rsp_tof_distance_cm;
            got.rssi_cm = rsp_rssi_distance_cm;
            got.errors = rsp_error_count;
            sb.check_result(got);
         end
         if (start && !busy) begin
            rd.tof = req_tof_ps;
            rd.local_idx = req_local_rssi;
            rd.remote_idx = req_remote_rssi;
            rd.ok = req_reading_ok;
            rd.last = req_last_reading;
            sb.note_reading(rd);
         end
         if (rsp_strobe || (start && !busy)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("tb: watchdog expired after %0d quiet cycles", IDLE_LIMIT);
            $display("tb: done, errors");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Unless steady, the sender idles in bursts: a run of back-to-back items, then a gap.
   task automatic pace();
      int gap;
      if (steady) return;
      if (pace_left > 0) begin
         pace_left--;
         return;
      end
      if ($urandom_range(0, 39) == 0) gap = $urandom_range(60, 250);
      else if ($urandom_range(0, 9) == 0) gap = $urandom_range(6, 40);
      else gap = $urandom_range(1, 5);
      start <= 1'b0;
      held_low = 1'b1;
      repeat (gap) @(posedge clock);
      pace_left = $urandom_range(0, 7);
   endtask

   task automatic send_reading(input logic signed [TOF_W-1:0] tof,
                               input logic [IDX_W-1:0] lr, input logic [IDX_W-1:0] rr,
                               input logic ok, input logic last);
      req_tof_ps <= tof;
      req_local_rssi <= lr;
      req_remote_rssi <= rr;
      req_reading_ok <= ok;
      req_last_reading <= last;
      start <= 1'b1;
      held_low = 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);
      n_sent++;
      pace();
   endtask

   function automatic logic signed [TOF_W-1:0] pick_tof(int mode);
      case (mode)
         0: return TOF_W'($urandom);
         1: return TOF_W'(int'($urandom_range(0, 150000)) - 2000);
         2: return TOF_W'(int'($urandom_range(0, 200)) - 100);
         default: begin
            case ($urandom_range(0, 3))
               0: return TOF_MAX;
               1: return TOF_MIN;
               2: return '0;
               default: return '1;
            endcase
         end
      endcase
   endfunction

   function automatic logic [IDX_W-1:0] pick_rssi();
      if ($urandom_range(0, 4) == 0) return IDX_W'($urandom_range(109, 127));
      return IDX_W'($urandom_range(0, 108));
   endfunction

   task automatic run_directed();
      // Single-reading bursts at the ToF and RSSI extremes.
      send_reading(TOF_MAX, 7'd0, 7'd0, 1'b1, 1'b1);
      send_reading(TOF_MIN, 7'd108, 7'd108, 1'b1, 1'b1);
      // A failed reading alone gives zero statistics and one error.
      send_reading(TOF_MAX, 7'd5, 7'd5, 1'b0, 1'b1);
      // RSSI indexes above the table saturate to its last entry.
      send_reading('0, 7'd127, 7'd109, 1'b1, 1'b1);
      // Failed reading in the middle of a burst is ignored apart from the count.
      send_reading(-24'sd5, 7'd3, 7'd4, 1'b1, 1'b0);
      send_reading(TOF_MAX, 7'd127, 7'd0, 1'b0, 1'b0);
      send_reading(24'sd7, 7'd50, 7'd60, 1'b1, 1'b1);
      send_reading(24'sd100, 7'd1, 7'd2, 1'b0, 1'b0);
      send_reading(24'sd200, 7'd1, 7'd2, 1'b0, 1'b1);
      // Widest spread between two readings.
      send_reading(TOF_MAX, 7'd20, 7'd30, 1'b1, 1'b0);
      send_reading(TOF_MIN, 7'd40, 7'd80, 1'b1, 1'b1);
      // Negative means truncate toward zero.
      send_reading(-24'sd101, 7'd64, 7'd1, 1'b1, 1'b0);
      send_reading(-24'sd200, 7'd33, 7'd90, 1'b1, 1'b1);
      send_reading(24'sd33, 7'd64, 7'd1, 1'b1, 1'b1);
      repeat (4) send_reading(TOF_MAX, 7'd100, 7'd7, 1'b1, 1'b0);
      send_reading(TOF_MAX, 7'd100, 7'd7, 1'b1, 1'b1);
   endtask

   task automatic run_random(input int target);
      int   kind;
      int   len;
      int   mode;
      int   ok_pct;
      int   first;
      logic ok_i;
      logic last_i;
      first = n_sent;
      while (n_sent - first < target) begin
         kind = $urandom_range(0, 99);
         steady = ($urandom_range(0, 5) == 0);
         ok_pct = ($urandom_range(0, 3) == 0) ? 50 : 90;
         mode = $urandom_range(0, 2);
         if (kind < 55) begin
            len = $urandom_range(1, 8);
         end else if (kind < 70) begin
            // Runs past the length cap; the block closes the burst on its own.
            len = $urandom_range(BURST_CAP + 1, BURST_CAP + 13);
         end else if (kind < 78) begin
            len = BURST_CAP;
         end else if (kind < 85) begin
            len = $urandom_range(1, 5);
            ok_pct = 0;
         end else if (kind < 92) begin
            len = $urandom_range(1, BURST_CAP);
            mode = 3;
         end else begin
            len = $urandom_range(1, 6);
         end
         for (int i = 0; i < len; i++) begin
            ok_i = ($urandom_range(0, 99) < ok_pct);
            last_i = (i == len - 1);
            if (kind >= 92) begin
               ok_i = 1'($urandom_range(0, 1));
               last_i = 1'($urandom_range(0, 1));
               mode = $urandom_range(0, 3);
            end
            send_reading(pick_tof(mode), pick_rssi(), pick_rssi(), ok_i, last_i);
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random(RANDOM_ITEMS);
      if (!held_low) start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("tb: %0d readings sent, %0d burst results checked",
               sb.readings_seen, sb.results_checked);
      $display("tb: %0d bursts closed by the length cap, %0d with no good reading",
               sb.cap_closed, sb.empty_bursts);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
